>>> rtl/sptq_pkg.sv
// Package for the stable priority task queue: sizes, entry type and codes.
// No dependencies; the top level and the checker use it by scoped names.
`default_nettype none
package sptq_pkg;
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [7:0]  tag;
        logic [7:0]  pri;
        logic [15:0] time_ms;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int KEY_W   = 16 + ADDR_W;

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_LIST = 2'd1;
    localparam logic [1:0] REQ_EXEC = 2'd2;

    localparam logic [1:0] ST_ENTRY = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;
endpackage
`default_nettype wire

>>> rtl/stable_priority_task_queue_unit.sv
// Top level of the stable priority task queue: sequencer around one task RAM.
// Depends on sptq_pkg and sptq_ram.
//
// Channel   Direction  Handshake                  Payload
// request   in         start & !busy              i_req_type, i_task_tag,
//                                                 i_task_priority, i_run_time_ms
// result    out        o_valid (one-cycle strobe) o_out_tag, o_out_priority,
//                                                 o_out_time_ms, o_status, o_last
//
// Add: into an empty store the task goes straight to the write state. Otherwise the walk
//   compares each stored task of lower priority (each shifts up one slot through the RAM
//   read port), then the entry that stops the walk unless the walk reaches slot 0, then
//   writes the new task. A full store is answered from idle.
// List: reads the tasks in slot order, one RAM read a cycle.
// Execute: n selection passes for n tasks, since the single RAM read port scans
//   every entry once per emitted task.
// Synchronous active-low reset empties the queue; RAM contents need no clear.
// The receiver cannot stall; busy holds off new requests until the last result.
`default_nettype none
module stable_priority_task_queue_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_task_tag,
    input  wire logic [7:0]  i_task_priority,
    input  wire logic [15:0] i_run_time_ms,
    output logic             o_valid,
    output logic [7:0]       o_out_tag,
    output logic [7:0]       o_out_priority,
    output logic [15:0]      o_out_time_ms,
    output logic [1:0]       o_status,
    output logic             o_last
);
    typedef enum logic [2:0] {S_IDLE, S_ADD_CMP, S_ADD_PUT, S_LIST, S_SCAN, S_EMIT} t_state;

    t_state                        r_state;
    logic [sptq_pkg::CNT_W-1:0]    r_count;
    logic [sptq_pkg::ADDR_W-1:0]   r_idx;      // add slot or address whose data arrives
    logic [sptq_pkg::CNT_W-1:0]    r_emitted;
    sptq_pkg::t_entry              r_new;
    sptq_pkg::t_entry              r_best;
    logic [sptq_pkg::KEY_W-1:0]    r_best_key;
    logic                          r_best_ok;
    logic [sptq_pkg::KEY_W-1:0]    r_last_key;
    logic                          r_have_last;

    logic                          rd_en;
    logic [sptq_pkg::ADDR_W-1:0]   rd_addr;
    logic                          wr_en;
    logic [sptq_pkg::ADDR_W-1:0]   wr_addr;
    sptq_pkg::t_entry              wr_data;
    sptq_pkg::t_entry              rd_data;
    logic [sptq_pkg::ENTRY_W-1:0]  rd_raw;

    logic                          accept;
    logic [sptq_pkg::ADDR_W-1:0]   cnt_m1;
    logic                          at_end;
    logic [sptq_pkg::KEY_W-1:0]    key;
    logic                          cand;
    logic                          shift;
    logic                          n_valid;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign rd_data = sptq_pkg::t_entry'(rd_raw);
    assign cnt_m1  = sptq_pkg::ADDR_W'(r_count - 1'b1);
    assign at_end  = (r_idx == cnt_m1);
    assign key     = {rd_data.time_ms, r_idx};
    assign cand    = (!r_have_last || key > r_last_key) && (!r_best_ok || key < r_best_key);
    assign shift   = rd_data.pri < r_new.pri;

    sptq_ram #(
        .WIDTH (sptq_pkg::ENTRY_W),
        .DEPTH (sptq_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    // RAM port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = r_new;
        unique case (r_state)
            S_IDLE: begin
                rd_en = accept;
                if (i_req_type == sptq_pkg::REQ_ADD) begin
                    rd_addr = cnt_m1;
                end
            end
            S_ADD_CMP: begin
                // move the lower-priority entry up one slot, fetch the next one down
                if (shift) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    rd_en   = (r_idx != 1);
                    rd_addr = r_idx - 2'd2;
                end
            end
            S_ADD_PUT: begin
                wr_en = 1'b1;
            end
            S_LIST, S_SCAN: begin
                rd_en   = !at_end;
                rd_addr = r_idx + 1'b1;
            end
            S_EMIT: begin
                rd_en = 1'b1;
            end
            default: ;
        endcase
    end

    // Result strobe: immediate status answers from idle, or a result state
    always_comb begin
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req_type == sptq_pkg::REQ_ADD) begin
                        n_valid = (r_count == sptq_pkg::CNT_W'(sptq_pkg::DEPTH));
                    end else if (i_req_type == sptq_pkg::REQ_LIST ||
                                 i_req_type == sptq_pkg::REQ_EXEC) begin
                        n_valid = (r_count == 0);
                    end
                end
            end
            S_ADD_PUT, S_LIST, S_EMIT: begin
                n_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_new          <= '{tag: i_task_tag, pri: i_task_priority,
                                            time_ms: i_run_time_ms};
                        r_idx          <= '0;
                        r_best_ok      <= 1'b0;
                        r_have_last    <= 1'b0;
                        r_emitted      <= '0;
                        o_out_tag      <= '0;
                        o_out_priority <= '0;
                        o_out_time_ms  <= '0;
                        o_last         <= 1'b1;
                        priority case (i_req_type)
                            sptq_pkg::REQ_ADD: begin
                                if (r_count == sptq_pkg::CNT_W'(sptq_pkg::DEPTH)) begin
                                    o_status <= sptq_pkg::ST_FULL;
                                end else begin
                                    r_idx   <= sptq_pkg::ADDR_W'(r_count);
                                    r_state <= (r_count == 0) ? S_ADD_PUT : S_ADD_CMP;
                                end
                            end
                            sptq_pkg::REQ_LIST, sptq_pkg::REQ_EXEC: begin
                                if (r_count == 0) begin
                                    o_status <= sptq_pkg::ST_EMPTY;
                                end else begin
                                    r_state <= (i_req_type == sptq_pkg::REQ_LIST)
                                               ? S_LIST : S_SCAN;
                                end
                            end
                            default: ;  // unused code: drop
                        endcase
                    end
                end
                S_ADD_CMP: begin
                    if (shift) begin
                        r_idx <= r_idx - 1'b1;
                        if (r_idx == 1) begin
                            r_state <= S_ADD_PUT;
                        end
                    end else begin
                        r_state <= S_ADD_PUT;
                    end
                end
                S_ADD_PUT: begin
                    r_count        <= r_count + 1'b1;
                    o_status       <= sptq_pkg::ST_OK;
                    o_last         <= 1'b1;
                    o_out_tag      <= '0;
                    o_out_priority <= '0;
                    o_out_time_ms  <= '0;
                    r_state        <= S_IDLE;
                end
                S_LIST: begin
                    o_status       <= sptq_pkg::ST_ENTRY;
                    o_last         <= at_end;
                    o_out_tag      <= rd_data.tag;
                    o_out_priority <= rd_data.pri;
                    o_out_time_ms  <= rd_data.time_ms;
                    r_idx          <= r_idx + 1'b1;
                    if (at_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    // keep the smallest (time, slot) above the last one emitted
                    if (cand) begin
                        r_best     <= rd_data;
                        r_best_key <= key;
                        r_best_ok  <= 1'b1;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (at_end) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_status       <= sptq_pkg::ST_ENTRY;
                    o_last         <= (r_emitted + 1'b1 == r_count);
                    o_out_tag      <= r_best.tag;
                    o_out_priority <= r_best.pri;
                    o_out_time_ms  <= r_best.time_ms;
                    r_emitted      <= r_emitted + 1'b1;
                    r_last_key     <= r_best_key;
                    r_have_last    <= 1'b1;
                    r_best_ok      <= 1'b0;
                    r_idx          <= '0;
                    r_state        <= (r_emitted + 1'b1 == r_count) ? S_IDLE : S_SCAN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/sptq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sptq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/sptq_checker.sv
// Port-level checker for stable_priority_task_queue_unit and its bind.
// Depends on sptq_pkg and the top level's port list.
`default_nettype none
module sptq_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_req_type,
    input wire logic       o_valid,
    input wire logic [1:0] o_status,
    input wire logic       o_last
);
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy) else $error("busy right after reset");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == sptq_pkg::REQ_ADD ||
                            i_req_type == sptq_pkg::REQ_LIST ||
                            i_req_type == sptq_pkg::REQ_EXEC)) |=> (busy || o_valid))
        else $error("request neither worked on nor answered");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy) else $error("busy after last transfer");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != sptq_pkg::ST_ENTRY) |-> o_last)
        else $error("status result not marked last");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy) else $error("drain stopped early");
endmodule

bind stable_priority_task_queue_unit sptq_checker u_sptq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_valid    (o_valid),
    .o_status   (o_status),
    .o_last     (o_last)
);
`default_nettype wire

>>> dv/stable_priority_task_queue_unit_tb.sv
// Self-checking testbench for stable_priority_task_queue_unit: adds, priority
// lists and time-ordered executes checked against a scoreboard model.
// Depends on sptq_pkg and the RTL of the unit.
module stable_priority_task_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Request code 3 is unused; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        sptq_pkg::t_entry ent;
        logic [1:0]       status;
        logic             last;
    } t_task_result;

    // Scoreboard: mirror of the task store plus the queue of pending results.
    class sptq_scoreboard;
        sptq_pkg::t_entry task_store[$];
        t_task_result     pending_results[$];
        int               errors = 0;

        function void push_result(sptq_pkg::t_entry e, logic [1:0] st, logic lst);
            t_task_result r;
            r.ent = e;
            r.status = st;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        // Note one accepted request and queue the results it must produce.
        function void note_request(logic [1:0] req, sptq_pkg::t_entry e);
            sptq_pkg::t_entry zero_ent;
            int               order[$];
            int               pos;
            int               j;
            int               cur;
            zero_ent = '0;
            case (req)
                sptq_pkg::REQ_ADD: begin
                    if (task_store.size() >= sptq_pkg::DEPTH) begin
                        push_result(zero_ent, sptq_pkg::ST_FULL, 1'b1);
                    end else begin
                        // Go behind every task of greater or equal priority.
                        pos = 0;
                        while (pos < task_store.size() && task_store[pos].pri >= e.pri)
                            pos++;
                        task_store.insert(pos, e);
                        push_result(zero_ent, sptq_pkg::ST_OK, 1'b1);
                    end
                end
                sptq_pkg::REQ_LIST, sptq_pkg::REQ_EXEC: begin
                    if (task_store.size() == 0) begin
                        push_result(zero_ent, sptq_pkg::ST_EMPTY, 1'b1);
                    end else begin
                        for (int i = 0; i < task_store.size(); i++)
                            order.push_back(i);
                        if (req == sptq_pkg::REQ_EXEC) begin
                            // Stable insertion sort by ascending time.
                            for (int i = 1; i < order.size(); i++) begin
                                cur = order[i];
                                j = i;
                                while (j > 0 && task_store[order[j-1]].time_ms >
                                       task_store[cur].time_ms) begin
                                    order[j] = order[j-1];
                                    j--;
                                end
                                order[j] = cur;
                            end
                        end
                        for (int i = 0; i < order.size(); i++)
                            push_result(task_store[order[i]], sptq_pkg::ST_ENTRY,
                                        i == order.size() - 1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_task_result got);
            t_task_result exp_r;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result tag=%0d pri=%0d time=%0d st=%0d last=%0d",
                             got.ent.tag, got.ent.pri, got.ent.time_ms, got.status, got.last);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.ent !== exp_r.ent || got.status !== exp_r.status ||
                got.last !== exp_r.last) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp tag=%0d pri=%0d time=%0d st=%0d last=%0d, got tag=%0d pri=%0d time=%0d st=%0d last=%0d",
                             exp_r.ent.tag, exp_r.ent.pri, exp_r.ent.time_ms,
                             exp_r.status, exp_r.last, got.ent.tag, got.ent.pri,
                             got.ent.time_ms, got.status, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_req_type = sptq_pkg::REQ_ADD;
    logic [7:0]  i_task_tag = '0;
    logic [7:0]  i_task_priority = '0;
    logic [15:0] i_run_time_ms = '0;
    logic        o_valid;
    logic [7:0]  o_out_tag;
    logic [7:0]  o_out_priority;
    logic [15:0] o_out_time_ms;
    logic [1:0]  o_status;
    logic        o_last;

    sptq_scoreboard task_board = new();
    int unsigned    cycle_count = 0;

    stable_priority_task_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_task_tag      (i_task_tag),
        .i_task_priority (i_task_priority),
        .i_run_time_ms   (i_run_time_ms),
        .o_valid         (o_valid),
        .o_out_tag       (o_out_tag),
        .o_out_priority  (o_out_priority),
        .o_out_time_ms   (o_out_time_ms),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: note every request transfer and check every result strobe.
    // Values read here are the ones present before the edge.
    always @(posedge i_clk) begin
        sptq_pkg::t_entry req_ent;
        t_task_result     got;
        if (i_rst_n) begin
            if (start && !busy) begin
                req_ent.tag = i_task_tag;
                req_ent.pri = i_task_priority;
                req_ent.time_ms = i_run_time_ms;
                task_board.note_request(i_req_type, req_ent);
            end
            if (o_valid) begin
                got.ent.tag = o_out_tag;
                got.ent.pri = o_out_priority;
                got.ent.time_ms = o_out_time_ms;
                got.status = o_status;
                got.last = o_last;
                task_board.check_result(got);
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, often none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and hold it until the transfer; with a zero gap start stays high so
    // a back-to-back request needs no second assignment in the same step.
    task automatic send_request(logic [1:0] req, logic [7:0] tag, logic [7:0] pri,
                                logic [15:0] tm, int gap);
        start <= 1'b1;
        i_req_type <= req;
        i_task_tag <= tag;
        i_task_priority <= pri;
        i_run_time_ms <= tm;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            start <= 1'b0;
            i_task_tag <= 8'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Priorities and times often drawn from narrow sets to force ties, plus extremes.
    function automatic logic [7:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3) * 85);
            1: return 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3) * 100);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int         accepted;
        logic [1:0] req;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, ignored code, extremes, ties in both keys.
        send_request(sptq_pkg::REQ_LIST, 8'h00, 8'h00, 16'h0000, 0);
        send_request(sptq_pkg::REQ_EXEC, 8'h00, 8'h00, 16'h0000, 1);
        send_request(REQ_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 0);
        send_request(sptq_pkg::REQ_ADD, 8'h01, 8'h80, 16'd500, 0);
        send_request(sptq_pkg::REQ_ADD, 8'h02, 8'h80, 16'd500, 2);
        send_request(sptq_pkg::REQ_ADD, 8'hFF, 8'hFF, 16'hFFFF, 0);
        send_request(sptq_pkg::REQ_ADD, 8'h00, 8'h00, 16'h0000, 0);
        send_request(sptq_pkg::REQ_ADD, 8'h03, 8'h80, 16'd100, 0);
        send_request(sptq_pkg::REQ_LIST, 8'h00, 8'h00, 16'h0000, 0);
        send_request(sptq_pkg::REQ_EXEC, 8'hAA, 8'h55, 16'hA5A5, 3);
        send_request(sptq_pkg::REQ_ADD, 8'h04, 8'h00, 16'hFFFF, 0);
        send_request(sptq_pkg::REQ_EXEC, 8'h00, 8'h00, 16'h0000, 0);

        // Random: adds are the most common request throughout, so the store fills
        // gradually; later come drains of a full store and rejected adds.
        accepted = 0;
        while (accepted < 300) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: req = sptq_pkg::REQ_ADD;
                4, 5, 6:    req = sptq_pkg::REQ_LIST;
                7, 8:       req = sptq_pkg::REQ_EXEC;
                default:    req = ($urandom_range(0, 3) == 0) ? REQ_UNUSED
                                                              : sptq_pkg::REQ_EXEC;
            endcase
            send_request(req, 8'($urandom), pick_priority(), pick_time(), pick_gap());
            if (req != REQ_UNUSED)
                accepted++;
            // Hold off once until the block has drained everything; wait for the
            // next edge first so the monitor has noted the last transfer.
            if (accepted == 150) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (task_board.pending_results.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (task_board.pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (task_board.errors == 0 && task_board.pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
